// ----- rtl/smx_pkg.sv -----
`timescale 1ns / 1ps
package smx_pkg;

   localparam int MAX_EQUATIONS_DEF = 1024;
   localparam int VALUE_DEPTH_DEF   = 65536;

   localparam int IDX_W      = 11;
   localparam int VAL_W      = 64;
   localparam int PTR_W      = 17;
   localparam int ACT_W      = 3;
   localparam int ST_W       = 3;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 64;

   localparam logic [IDX_W-1:0] EQ_COUNT_RESET = 11'd1024;

   localparam logic [ACT_W-1:0] ACT_LOAD  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ACC   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SET   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_GET   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

   localparam logic [ST_W-1:0] ST_OK      = 3'd0;
   localparam logic [ST_W-1:0] ST_IGNORED = 3'd1;
   localparam logic [ST_W-1:0] ST_OUTSIDE = 3'd2;
   localparam logic [ST_W-1:0] ST_RANGE   = 3'd3;
   localparam logic [ST_W-1:0] ST_SAT     = 3'd4;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_ACC,
      OP_SET,
      OP_GET,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [ST_W-1:0]   status;
      logic [IDX_W-1:0]  slot;
      logic [IDX_W-1:0]  off;
      logic [VAL_W-1:0]  value;
      logic [PTR_W-1:0]  ptr;
   } cmd_type;

endpackage

// ----- rtl/skyline_matrix_store.sv -----
`timescale 1ns / 1ps
// Symmetric matrix store in skyline form with Q31.32 saturating accumulate.
// Items enter a two-entry command queue after classification, so the request
// side keeps flowing while a result waits on the response side. The execution
// side handles one item at a time: rejected, ignored and pointer-load items are
// answered from the idle state, set reads the pointer table and then writes the
// value, get and accumulate read the pointer table, then the value, then give the
// result or do the read-modify-write (they end after the pointer table read when
// the entry falls outside the column or the value store), and clear zeroes all
// VALUE_DEPTH value store entries, one per cycle. The pointer table is kept as two
// copies so that a column's start and end are read in the same cycle; the single
// read port of the value store sets the accumulate time. The value store holds no
// defined contents until a clear: issue a clear before the first accumulate.
module skyline_matrix_store #(
   parameter int MAX_EQUATIONS = smx_pkg::MAX_EQUATIONS_DEF,
   parameter int VALUE_DEPTH   = smx_pkg::VALUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [smx_pkg::IDX_W-1:0]        csr_wr_data,  // equation_count
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // row[10:0], col[21:11], value[85:22], pointer_value[102:86], zero[103]
   input  logic [smx_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [smx_pkg::ACT_W-1:0]        req_tuser,    // action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [smx_pkg::RSP_DATA_W-1:0]   rsp_tdata,    // read_value
   output logic [smx_pkg::ST_W-1:0]         rsp_tuser     // status
);

   logic [smx_pkg::IDX_W-1:0] eq_count_ff;
   logic [smx_pkg::IDX_W-1:0] eq_count_in;
   logic                      cmd_valid;
   logic                      pop;
   smx_pkg::cmd_type          cmd;

   assign eq_count_in = csr_wr_en ? csr_wr_data : eq_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eq_count_ff <= smx_pkg::EQ_COUNT_RESET;
      end else begin
         eq_count_ff <= eq_count_in;
      end
   end

   smx_front #(.MAX_EQUATIONS(MAX_EQUATIONS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .equation_count (eq_count_ff),
      .pop            (pop),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd)
   );

   smx_back #(.MAX_EQUATIONS(MAX_EQUATIONS), .VALUE_DEPTH(VALUE_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/smx_ram.sv -----
`timescale 1ns / 1ps
module smx_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/smx_front.sv -----
`timescale 1ns / 1ps
module smx_front #(
   parameter int MAX_EQUATIONS = smx_pkg::MAX_EQUATIONS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [smx_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [smx_pkg::ACT_W-1:0]        req_tuser,
   input  logic [smx_pkg::IDX_W-1:0]        equation_count,
   input  logic                             pop,
   output logic                             cmd_valid,
   output smx_pkg::cmd_type                 cmd
);

   logic [smx_pkg::IDX_W-1:0] row_bits;
   logic [smx_pkg::IDX_W-1:0] col;
   logic                      row_neg;
   logic [smx_pkg::IDX_W-1:0] used_n;
   logic [smx_pkg::IDX_W-1:0] lo;
   logic [smx_pkg::IDX_W-1:0] hi;
   smx_pkg::cmd_type          cls;

   smx_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             push;
   logic             take;

   assign row_bits = req_tdata[10:0];
   assign col      = req_tdata[21:11];
   assign row_neg  = row_bits[smx_pkg::IDX_W-1];
   assign used_n   = (32'(equation_count) > 32'(MAX_EQUATIONS)) ?
                     smx_pkg::IDX_W'(MAX_EQUATIONS) : equation_count;
   assign lo       = (row_bits > col) ? col : row_bits;
   assign hi       = (row_bits > col) ? row_bits : col;

   always_comb begin
      cls.op     = smx_pkg::OP_NONE;
      cls.status = smx_pkg::ST_OK;
      cls.slot   = col;
      cls.off    = col - row_bits;
      cls.value  = req_tdata[85:22];
      cls.ptr    = req_tdata[102:86];
      unique case (req_tuser)
         smx_pkg::ACT_LOAD: begin
            if (col > used_n) cls.status = smx_pkg::ST_RANGE;
            else cls.op = smx_pkg::OP_LOAD;
         end
         smx_pkg::ACT_ACC, smx_pkg::ACT_SET: begin
            if (row_neg || row_bits > col) cls.status = smx_pkg::ST_IGNORED;
            else if (col >= used_n) cls.status = smx_pkg::ST_RANGE;
            else if (req_tuser == smx_pkg::ACT_ACC) cls.op = smx_pkg::OP_ACC;
            else cls.op = smx_pkg::OP_SET;
         end
         smx_pkg::ACT_GET: begin
            cls.slot = hi;
            cls.off  = hi - lo;
            if (row_neg || hi >= used_n) cls.status = smx_pkg::ST_RANGE;
            else cls.op = smx_pkg::OP_GET;
         end
         smx_pkg::ACT_CLEAR: begin
            cls.op = smx_pkg::OP_CLEAR;
         end
         default: begin
            cls.status = smx_pkg::ST_IGNORED;
         end
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign take       = pop && cmd_valid;
   assign cmd        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- rtl/smx_back.sv -----
`timescale 1ns / 1ps
module smx_back #(
   parameter int MAX_EQUATIONS = smx_pkg::MAX_EQUATIONS_DEF,
   parameter int VALUE_DEPTH   = smx_pkg::VALUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  smx_pkg::cmd_type                 cmd,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [smx_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [smx_pkg::ST_W-1:0]         rsp_tuser
);

   localparam int PW = $clog2(MAX_EQUATIONS + 1);
   localparam int AW = $clog2(VALUE_DEPTH);
   localparam logic [31:0]   VD32    = 32'(VALUE_DEPTH);
   localparam logic [AW-1:0] CLR_END = AW'(VALUE_DEPTH - 1);
   localparam logic [63:0]   SAT_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0]   SAT_MIN = {1'b1, {63{1'b0}}};

   typedef enum logic [1:0] {
      S_IDLE,
      S_PTR,
      S_VAL,
      S_CLEAR
   } state_type;

   state_type                       state_ff, state_in;
   smx_pkg::cmd_type                cmd_ff, cmd_in;
   logic [17:0]                     addr_ff, addr_in;
   logic [AW-1:0]                   clr_cnt_ff, clr_cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [smx_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [smx_pkg::ST_W-1:0]        rsp_status_ff, rsp_status_in;

   logic                            ptr_wr;
   logic                            ptr_rd;
   logic [PW-1:0]                   ptr_addr0;
   logic [PW-1:0]                   ptr_addr1;
   logic [smx_pkg::PTR_W-1:0]       ptr_start;
   logic [smx_pkg::PTR_W-1:0]       ptr_end;
   logic                            val_wr;
   logic [AW-1:0]                   val_wr_addr;
   logic [63:0]                     val_wr_data;
   logic                            val_rd;
   logic [AW-1:0]                   val_rd_addr;
   logic [63:0]                     val_rd_data;

   logic [17:0]                     addr;
   logic                            in_prof;
   logic                            in_mem;
   logic [63:0]                     sum;
   logic                            ovf;
   logic                            out_free;

   assign ptr_addr0 = PW'(cmd.slot);
   assign ptr_addr1 = PW'({1'b0, cmd.slot} + 12'd1);

   smx_ram #(.WIDTH(smx_pkg::PTR_W), .DEPTH(MAX_EQUATIONS + 1)) u_ptr_lo (
      .clock   (clock),
      .wr_en   (ptr_wr),
      .wr_addr (ptr_addr0),
      .wr_data (cmd.ptr),
      .rd_en   (ptr_rd),
      .rd_addr (ptr_addr0),
      .rd_data (ptr_start)
   );

   smx_ram #(.WIDTH(smx_pkg::PTR_W), .DEPTH(MAX_EQUATIONS + 1)) u_ptr_hi (
      .clock   (clock),
      .wr_en   (ptr_wr),
      .wr_addr (ptr_addr0),
      .wr_data (cmd.ptr),
      .rd_en   (ptr_rd),
      .rd_addr (ptr_addr1),
      .rd_data (ptr_end)
   );

   smx_ram #(.WIDTH(64), .DEPTH(VALUE_DEPTH)) u_values (
      .clock   (clock),
      .wr_en   (val_wr),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (val_rd),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   assign addr     = {1'b0, ptr_start} + {7'b0, cmd_ff.off};
   assign in_prof  = ({1'b0, ptr_end} > addr);
   assign in_mem   = ({14'b0, addr} < VD32);
   assign sum      = val_rd_data + cmd_ff.value;
   assign ovf      = (val_rd_data[63] == cmd_ff.value[63]) && (sum[63] != val_rd_data[63]);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      clr_cnt_in    = clr_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      pop           = 1'b0;
      ptr_wr        = 1'b0;
      ptr_rd        = 1'b0;
      val_wr        = 1'b0;
      val_wr_addr   = AW'(addr_ff);
      val_wr_data   = cmd_ff.value;
      val_rd        = 1'b0;
      val_rd_addr   = AW'(addr);
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               pop    = 1'b1;
               cmd_in = cmd;
               unique case (cmd.op)
                  smx_pkg::OP_LOAD: begin
                     ptr_wr        = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = '0;
                     rsp_status_in = smx_pkg::ST_OK;
                  end
                  smx_pkg::OP_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = S_CLEAR;
                  end
                  smx_pkg::OP_ACC, smx_pkg::OP_SET, smx_pkg::OP_GET: begin
                     ptr_rd   = 1'b1;
                     state_in = S_PTR;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_data_in   = '0;
                     rsp_status_in = cmd.status;
                  end
               endcase
            end
         end
         S_PTR: begin
            addr_in     = addr;
            rsp_data_in = '0;
            state_in    = S_IDLE;
            if (cmd_ff.op == smx_pkg::OP_GET) begin
               if (!in_prof) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = smx_pkg::ST_OK;
               end else if (!in_mem) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = smx_pkg::ST_OUTSIDE;
               end else begin
                  val_rd   = 1'b1;
                  state_in = S_VAL;
               end
            end else if (!(in_prof && in_mem)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = smx_pkg::ST_OUTSIDE;
            end else if (cmd_ff.op == smx_pkg::OP_SET) begin
               val_wr        = 1'b1;
               val_wr_addr   = AW'(addr);
               rsp_valid_in  = 1'b1;
               rsp_status_in = smx_pkg::ST_OK;
            end else begin
               val_rd   = 1'b1;
               state_in = S_VAL;
            end
         end
         S_VAL: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (cmd_ff.op == smx_pkg::OP_GET) begin
               rsp_data_in   = val_rd_data;
               rsp_status_in = smx_pkg::ST_OK;
            end else begin
               val_wr        = 1'b1;
               val_wr_data   = ovf ? (val_rd_data[63] ? SAT_MIN : SAT_MAX) : sum;
               rsp_data_in   = '0;
               rsp_status_in = ovf ? smx_pkg::ST_SAT : smx_pkg::ST_OK;
            end
         end
         S_CLEAR: begin
            val_wr      = 1'b1;
            val_wr_addr = clr_cnt_ff;
            val_wr_data = '0;
            if (clr_cnt_ff == CLR_END) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = smx_pkg::ST_OK;
               state_in      = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      clr_cnt_ff    <= clr_cnt_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- rtl/smx_checker.sv -----
`timescale 1ns / 1ps
module smx_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [smx_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [smx_pkg::ST_W-1:0]         rsp_tuser
);

   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("response pending or request blocked after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == smx_pkg::ST_OK || rsp_tuser == smx_pkg::ST_IGNORED ||
                      rsp_tuser == smx_pkg::ST_OUTSIDE || rsp_tuser == smx_pkg::ST_RANGE ||
                      rsp_tuser == smx_pkg::ST_SAT))
      else $error("undefined status code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != smx_pkg::ST_OK |-> rsp_tdata == '0)
      else $error("nonzero read value with error status");

endmodule

bind skyline_matrix_store smx_checker u_smx_checker (.*);
